/* rtl/jkse_pkg.sv */
package jkse_pkg;

    // text characters the matcher and decoder look for
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    // configuration register indexes
    localparam logic CFG_KEY_BYTES  = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_FOUND   = 2'd1,
        KIND_MISSING = 2'd2
    } t_kind;

    // one result item
    typedef struct packed {
        logic [7:0] value_byte;
        t_kind      result_kind;
        logic       final_res;
    } t_result;

    // window control from the top level to every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage

/* rtl/jkse_cell.sv */
module jkse_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jkse_pkg::t_win_ctl i_ctl,
    input  logic [7:0]         i_din,
    input  logic [3:0]         i_klen,
    input  logic [63:0]        i_key_bytes,
    output logic [7:0]         o_byte,
    output logic               o_ok
);

    localparam logic [4:0] IDX_V = 5'(IDX);

    logic [7:0] r_byte;
    logic [7:0] w_expect;
    logic [4:0] w_len;
    logic [4:0] w_kidx;

    // pattern byte this position must hold, newest byte at position zero
    assign w_len  = {1'b0, i_klen} + 5'd4;
    assign w_kidx = {1'b0, i_klen} + 5'd2 - IDX_V;

    always_comb begin
        if (IDX_V == 5'd0 || IDX_V == 5'd2) begin
            w_expect = jkse_pkg::CH_QUOTE;
        end else if (IDX_V == 5'd1) begin
            w_expect = jkse_pkg::CH_COLON;
        end else if (IDX_V <= {1'b0, i_klen} + 5'd2) begin
            w_expect = i_key_bytes[{w_kidx[2:0], 3'b000} +: 8];
        end else begin
            w_expect = jkse_pkg::CH_QUOTE;
        end
    end

    // compare the byte that enters this cell, positions past the pattern always agree
    assign o_ok = (IDX_V >= w_len) || (i_din == w_expect);

    // window byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_byte <= 8'h00;
        end else if (i_ctl.shift) begin
            r_byte <= i_din;
        end
    end

    assign o_byte = r_byte;

endmodule

/* rtl/jkse_outq.sv */
module jkse_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  jkse_pkg::t_result i_push0,
    input  jkse_pkg::t_result i_push1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output jkse_pkg::t_result o_head
);

    jkse_pkg::t_result r_q [3];
    jkse_pkg::t_result n_q [3];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              w_pop;
    logic [1:0]        w_base;

    assign w_pop  = (r_cnt != 2'd0) && i_ready;
    assign w_base = r_cnt - {1'b0, w_pop};

    // shift out the head, then append up to two new items
    always_comb begin
        n_q[0] = w_pop ? r_q[1] : r_q[0];
        n_q[1] = w_pop ? r_q[2] : r_q[1];
        n_q[2] = r_q[2];
        for (int i = 0; i < 3; i++) begin
            if (i_push_cnt != 2'd0 && w_base == 2'(i)) begin
                n_q[i] = i_push0;
            end
            if (i_push_cnt == 2'd2 && w_base + 2'd1 == 2'(i)) begin
                n_q[i] = i_push1;
            end
        end
        n_cnt = w_base + i_push_cnt;
    end

    // queue storage and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

    assign o_room  = (r_cnt <= 2'd1);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];

endmodule

/* rtl/json_key_string_extractor.sv */
// Finds the first  "key":"  in a JSON text streamed one byte per item and
// emits the string value that follows, escapes decoded (\b \f \n \r \t to
// control codes, any other escaped byte as is), then a found item; reaching
// the end of text first gives a not-found item, and the characters already
// sent are to be discarded. Bytes after a found item are dropped. Every text
// starts fresh after its tlast byte; key registers are kept. The key (up to
// MAX_KEY_CHARS characters) is matched by a row of MAX_KEY_CHARS+4 window
// cells, one byte each, all compared in the cycle a byte enters. One text
// byte is taken per clock. A byte yields at most two result items (only a
// final byte that carries a value character), held in a three-entry output
// queue; result items are registered in that queue before they are offered.
// s_axis_tready is high while that queue holds at most one item, so the input
// runs at one byte per clock as long as results are drained one per clock,
// apart from a stall after a final byte that yields two items.
// Configuration writes are always ready and belong between texts.
module json_key_string_extractor #(
    parameter int MAX_KEY_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // text in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    // results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] value_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast    // final_res
);

    localparam int         WIN_DEPTH = MAX_KEY_CHARS + 4;
    localparam logic [3:0] MAX_K     = 4'(MAX_KEY_CHARS);

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_VALUE  = 2'd1,
        PH_ESCAPE = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [63:0] r_key_bytes;
    logic [3:0]  r_key_length;
    logic [3:0]  w_klen;

    logic               w_fire;
    logic               w_match;
    jkse_pkg::t_win_ctl w_ctl;
    logic [7:0]         w_win [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] w_ok;

    logic [1:0]        w_push_cnt;
    jkse_pkg::t_result w_push0;
    jkse_pkg::t_result w_push1;
    jkse_pkg::t_result w_head;
    logic              w_room;

    function automatic logic [7:0] decode_escape(input logic [7:0] e);
        logic [7:0] d;
        case (e)
            jkse_pkg::CH_LC_B: d = 8'h08;
            jkse_pkg::CH_LC_F: d = 8'h0C;
            jkse_pkg::CH_LC_N: d = 8'h0A;
            jkse_pkg::CH_LC_R: d = 8'h0D;
            jkse_pkg::CH_LC_T: d = 8'h09;
            default:           d = e;
        endcase
        return d;
    endfunction

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes  <= 64'd0;
            r_key_length <= 4'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jkse_pkg::CFG_KEY_BYTES:  r_key_bytes  <= i_cfg_data;
                jkse_pkg::CFG_KEY_LENGTH: r_key_length <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign w_klen = (r_key_length > MAX_K) ? MAX_K : r_key_length;

    // window row
    assign w_fire    = s_axis_tvalid && s_axis_tready;
    assign w_ctl.shift = w_fire && (r_phase == PH_SEARCH);
    assign w_ctl.clear = w_fire && s_axis_tlast;

    for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
        logic [7:0] w_din;
        if (j == 0) begin : g_first
            assign w_din = s_axis_tdata;
        end else begin : g_next
            assign w_din = w_win[j-1];
        end
        jkse_cell #(
            .IDX (j)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_din       (w_din),
            .i_klen      (w_klen),
            .i_key_bytes (r_key_bytes),
            .o_byte      (w_win[j]),
            .o_ok        (w_ok[j])
        );
    end

    assign w_match = &w_ok;

    // phase step and result items for the accepted byte
    always_comb begin
        jkse_pkg::t_result w_main;
        logic              w_has_main;
        w_main     = '{value_byte: 8'h00, result_kind: jkse_pkg::KIND_CHAR, final_res: 1'b0};
        w_has_main = 1'b0;
        n_phase    = r_phase;
        case (r_phase)
            PH_SEARCH: begin
                if (w_match) begin
                    n_phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (s_axis_tdata == jkse_pkg::CH_QUOTE) begin
                    w_main = '{value_byte: 8'h00, result_kind: jkse_pkg::KIND_FOUND,
                               final_res: 1'b1};
                    w_has_main = 1'b1;
                    n_phase    = PH_DONE;
                end else if (s_axis_tdata == jkse_pkg::CH_BSLASH && !s_axis_tlast) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    w_main.value_byte = s_axis_tdata;
                    w_has_main        = 1'b1;
                end
            end
            PH_ESCAPE: begin
                w_main.value_byte = decode_escape(s_axis_tdata);
                w_has_main        = 1'b1;
                n_phase           = PH_VALUE;
            end
            default: ;
        endcase

        // end of text: not-found item unless already found, then start over
        w_push0 = w_main;
        w_push1 = '{value_byte: 8'h00, result_kind: jkse_pkg::KIND_MISSING, final_res: 1'b1};
        w_push_cnt = {1'b0, w_has_main};
        if (s_axis_tlast) begin
            if (n_phase != PH_DONE) begin
                if (w_has_main) begin
                    w_push_cnt = 2'd2;
                end else begin
                    w_push0    = w_push1;
                    w_push_cnt = 2'd1;
                end
            end
            n_phase = PH_SEARCH;
        end
        if (!w_fire) begin
            w_push_cnt = 2'd0;
            n_phase    = r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
        end else begin
            r_phase <= n_phase;
        end
    end

    // output queue
    jkse_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_push0    (w_push0),
        .i_push1    (w_push1),
        .o_room     (w_room),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_head     (w_head)
    );

    assign s_axis_tready = w_room;
    assign m_axis_tdata  = w_head.value_byte;
    assign m_axis_tuser  = w_head.result_kind;
    assign m_axis_tlast  = w_head.final_res;

endmodule

/* tb/sv/jkse_value_checker.sv */
// watches the config, text and result channels of the extractor, keeps its
// own copy of the key registers and text state, predicts the result items of
// every accepted text byte and compares them in order with the results seen
module jkse_value_checker #(
    parameter int MAX_KEY_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // text channel
    input  logic        i_text_valid,
    input  logic        i_text_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_text_last,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [7:0]  i_res_value,
    input  logic [1:0]  i_res_kind,
    input  logic        i_res_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import jkse_pkg::*;

    localparam int WIN_DEPTH = MAX_KEY_CHARS + 4;

    typedef enum logic [1:0] {
        SCAN_KEY,
        IN_VALUE,
        AFTER_BSLASH,
        VALUE_DONE
    } t_scan;

    logic [63:0] key_chars;
    logic [3:0]  key_count;
    logic [7:0]  recent_bytes [WIN_DEPTH];
    t_scan       scan;
    t_result     value_items_due [$];

    // byte p of  "key":"  with klen key characters
    function automatic logic [7:0] pattern_at(int p, int klen);
        if (p == 0) return CH_QUOTE;
        if (p <= klen) return key_chars[8*(p-1) +: 8];
        if (p == klen + 1) return CH_QUOTE;
        if (p == klen + 2) return CH_COLON;
        return CH_QUOTE;
    endfunction

    // newest bytes of the window against the whole pattern
    function automatic logic key_seen();
        int klen;
        int span;
        klen = (key_count > MAX_KEY_CHARS) ? MAX_KEY_CHARS : int'(key_count);
        span = klen + 4;
        for (int p = 0; p < span; p++) begin
            if (recent_bytes[span-1-p] !== pattern_at(p, klen)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] e);
        case (e)
            CH_LC_B: return 8'h08;
            CH_LC_F: return 8'h0C;
            CH_LC_N: return 8'h0A;
            CH_LC_R: return 8'h0D;
            CH_LC_T: return 8'h09;
            default: return e;
        endcase
    endfunction

    task automatic queue_result(input logic [7:0] v, input t_kind k, input logic fin);
        t_result r;
        r.value_byte  = v;
        r.result_kind = k;
        r.final_res   = fin;
        value_items_due.push_back(r);
    endtask

    task automatic clear_text();
        for (int i = 0; i < WIN_DEPTH; i++) recent_bytes[i] = 8'h00;
        scan = SCAN_KEY;
    endtask

    // expected results of one text byte
    task automatic predict_byte(input logic [7:0] b, input logic last);
        case (scan)
            SCAN_KEY: begin
                for (int i = WIN_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
                recent_bytes[0] = b;
                if (key_seen()) scan = IN_VALUE;
            end
            IN_VALUE: begin
                if (b == CH_QUOTE) begin
                    queue_result(8'h00, KIND_FOUND, 1'b1);
                    scan = VALUE_DONE;
                end else if (b == CH_BSLASH && !last) begin
                    scan = AFTER_BSLASH;
                end else begin
                    queue_result(b, KIND_CHAR, 1'b0);
                end
            end
            AFTER_BSLASH: begin
                queue_result(unescape(b), KIND_CHAR, 1'b0);
                scan = IN_VALUE;
            end
            default: ;
        endcase
        if (last) begin
            if (scan != VALUE_DONE) queue_result(8'h00, KIND_MISSING, 1'b1);
            clear_text();
        end
    endtask

    // prediction goes first, before the result seen at the same edge is compared
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            key_chars = '0;
            key_count = '0;
            clear_text();
            value_items_due.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_KEY_BYTES) key_chars = i_cfg_data;
                else if (i_cfg_index == CFG_KEY_LENGTH) key_count = i_cfg_data[3:0];
            end
            if (i_text_valid && i_text_ready) predict_byte(i_text_byte, i_text_last);
            if (i_res_valid && i_res_ready) begin
                o_checked++;
                if (value_items_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result: value %02h kind %0d last %0b",
                             $time, i_res_value, i_res_kind, i_res_last);
                end else begin
                    want = value_items_due.pop_front();
                    if (i_res_value !== want.value_byte || i_res_kind !== want.result_kind ||
                        i_res_last !== want.final_res) begin
                        o_fail_count++;
                        $display("%0t: result mismatch: expected value %02h kind %0d last %0b, %s",
                                 $time, want.value_byte, want.result_kind, want.final_res,
                                 $sformatf("got value %02h kind %0d last %0b",
                                           i_res_value, i_res_kind, i_res_last));
                    end
                end
            end
        end
        o_pending = value_items_due.size();
    end

endmodule

/* tb/sv/testbench.sv */
// streams JSON texts into the key string extractor under several key settings
// and handshake pressures; the checker predicts and compares every result
module testbench;
    import jkse_pkg::*;

    localparam int MAX_KEY        = 8;
    localparam int NUM_SETTINGS   = 12;
    localparam int BYTES_PER_KEY  = 118;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_KEY_BYTES;
    logic [63:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int chk_failures;
    int chk_pending;
    int chk_checked;

    // stimulus bookkeeping
    logic [7:0]  text_bytes [$];
    logic [63:0] cur_key;
    logic [3:0]  cur_len;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent = 0;
    int          texts_sent = 0;
    int          keys_loaded = 0;

    json_key_string_extractor #(.MAX_KEY_CHARS(MAX_KEY)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    jkse_value_checker #(.MAX_KEY_CHARS(MAX_KEY)) value_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_text_valid (s_axis_tvalid),
        .i_text_ready (s_axis_tready),
        .i_text_byte  (s_axis_tdata),
        .i_text_last  (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_value  (m_axis_tdata),
        .i_res_kind   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_fail_count (chk_failures),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // safety net against a hung handshake
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    // one text byte, with an optional idle gap in front
    task automatic put_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++) begin
            put_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
        texts_sent++;
    endtask

    // hold the sender until every expected result is out, then let it settle
    task automatic drain_results(input int quiet_cycles);
        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (quiet_cycles) @(negedge i_clk);
    endtask

    task automatic load_key(input logic [63:0] chars, input logic [3:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_KEY_BYTES;
        i_cfg_data  <= chars;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= CFG_KEY_LENGTH;
        i_cfg_data  <= {60'd0, count};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_key = chars;
        cur_len = count;
        keys_loaded++;
    endtask

    function automatic logic [63:0] letter_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++) k[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
        return k;
    endfunction

    // punctuation, spaces, letters and random bytes found around a JSON member
    function automatic logic [7:0] json_filler();
        case ($urandom_range(9))
            0: return 8'h7B;
            1: return 8'h7D;
            2: return 8'h2C;
            3: return CH_COLON;
            4: return CH_QUOTE;
            5: return 8'h20;
            6, 7: return 8'h61 + 8'($urandom_range(25));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] escape_code();
        case ($urandom_range(8))
            0: return CH_LC_B;
            1: return CH_LC_F;
            2: return CH_LC_N;
            3: return CH_LC_R;
            4: return CH_LC_T;
            5: return CH_QUOTE;
            6: return CH_BSLASH;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed "key":"value" texts with random content,
    // plus corrupted patterns and plain noise
    task automatic build_text();
        int roll;
        int klen;
        int start;
        int ending;
        text_bytes.delete();
        klen = (cur_len > MAX_KEY) ? MAX_KEY : int'(cur_len);
        roll = $urandom_range(99);
        if (roll < 12) begin
            repeat ($urandom_range(1, 12)) text_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(0, 5)) text_bytes.push_back(json_filler());
        // near miss: right key, value not a string
        if ($urandom_range(3) == 0) begin
            text_bytes.push_back(CH_QUOTE);
            for (int i = 0; i < klen; i++) text_bytes.push_back(cur_key[8*i +: 8]);
            text_bytes.push_back(CH_QUOTE);
            text_bytes.push_back(CH_COLON);
            text_bytes.push_back(8'h31);
            text_bytes.push_back(8'h2C);
        end
        start = text_bytes.size();
        text_bytes.push_back(CH_QUOTE);
        for (int i = 0; i < klen; i++) text_bytes.push_back(cur_key[8*i +: 8]);
        text_bytes.push_back(CH_QUOTE);
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back(CH_QUOTE);
        // broken pattern: one bit flipped somewhere in it
        if (roll < 24) begin
            text_bytes[start + $urandom_range(klen + 3)] ^= 8'(1 << $urandom_range(7));
        end
        // text ends on the opening quote of the value
        if ($urandom_range(9) == 0) return;
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(3) == 0) begin
                text_bytes.push_back(CH_BSLASH);
                text_bytes.push_back(escape_code());
            end else begin
                text_bytes.push_back(plain_char());
            end
        end
        ending = $urandom_range(99);
        if (ending < 15) begin
            text_bytes.push_back(CH_BSLASH);
        end else if (ending < 30) begin
            if (text_bytes.size() == 0) text_bytes.push_back(plain_char());
        end else if (ending < 45) begin
            text_bytes.push_back(CH_QUOTE);
        end else begin
            text_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(1, 4)) text_bytes.push_back(json_filler());
        end
    endtask

    initial begin
        logic [63:0] k;
        logic [3:0]  n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed texts with the empty key
        load_key(64'h0, 4'd0);
        // escape, byte extremes, closing quote, a byte after found
        text_bytes = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, 8'hFF, CH_BSLASH, CH_LC_N,
                       8'h00, CH_QUOTE, 8'h2C};
        send_text();
        // match on the final byte
        text_bytes = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE};
        send_text();
        // backslash on the final byte
        text_bytes = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, CH_BSLASH};
        send_text();
        // escaped byte on the final byte
        text_bytes = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, CH_BSLASH, CH_LC_R};
        send_text();

        // random texts, one key setting and one handshake pressure per pass
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            case (s)
                0: begin k = letter_key(); n = 4'd8; end
                1: begin k = {$urandom, $urandom}; n = 4'd0; end
                2: begin k = letter_key(); n = 4'd15; end
                3: begin k = letter_key(); n = 4'd1; end
                4: begin k = '1; n = 4'd8; end
                5: begin k = '0; n = 4'd3; end
                default: begin
                    k = ($urandom_range(1) == 0) ? letter_key() : {$urandom, $urandom};
                    n = 4'($urandom_range(15));
                end
            endcase
            drain_results(8);
            load_key(k, n);
            case (s % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            begin
                int sent_here;
                sent_here = 0;
                while (sent_here < BYTES_PER_KEY) begin
                    build_text();
                    send_text();
                    sent_here += text_bytes.size();
                end
            end
        end

        drain_results(20);
        $display("covered %0d text bytes in %0d texts across %0d key settings",
                 bytes_sent, texts_sent, keys_loaded);
        $display("compared %0d result items, %0d mismatched or unexpected",
                 chk_checked, chk_failures);
        if (chk_failures == 0 && chk_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
